// ===== hw/rtl/ccg_pkg.sv =====
// ----------------------------------------------------------------------------
// ccg_pkg
// Types and constants shared by the character cell grid engine.
// ----------------------------------------------------------------------------
package ccg_pkg;

    localparam logic [2:0] K_CLEAR      = 3'd0;
    localparam logic [2:0] K_WRITE      = 3'd1;
    localparam logic [2:0] K_READ       = 3'd2;
    localparam logic [2:0] K_SCROLL     = 3'd3;
    localparam logic [2:0] K_MARK       = 3'd4;
    localparam logic [2:0] K_MARK_ALL   = 3'd5;
    localparam logic [2:0] K_CLEAR_DIRT = 3'd6;
    localparam logic [2:0] K_FIND       = 3'd7;

    localparam logic       CFG_COLS = 1'b0;
    localparam logic       CFG_ROWS = 1'b1;

    localparam logic [20:0] BLANK_GLYPH = 21'h20;

    typedef struct packed {
        logic [20:0] glyph;
        logic [15:0] attr;
        logic        dirty;
        logic        wide;
        logic        tail;
    } t_cell;

    localparam t_cell BLANK_CELL = '{glyph: BLANK_GLYPH, attr: 16'd0, dirty: 1'b1,
                                     wide: 1'b0, tail: 1'b0};

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  cell_col;
        logic [6:0]  cell_row;
        logic [20:0] glyph;
        logic [15:0] attribute;
        logic        wide;
        logic [6:0]  region_top;
        logic [6:0]  region_bottom;
        logic [7:0]  region_left;
        logic [7:0]  region_right;
        logic [7:0]  scroll_amount;
    } t_cmd;

    typedef struct packed {
        logic [20:0] out_glyph;
        logic [15:0] out_attribute;
        logic        out_dirty;
        logic        out_wide;
        logic        out_wide_tail;
        logic        hit;
        logic [6:0]  found_col;
        logic [5:0]  found_row;
    } t_res;

endpackage

// ===== hw/rtl/ccg_if.sv =====
// ----------------------------------------------------------------------------
// ccg_if
// Valid/ready channels: command, result and configuration write.
// ----------------------------------------------------------------------------
interface ccg_cmd_if import ccg_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccg_res_if import ccg_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccg_cfg_if ();
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/character_cell_grid_engine_top.sv =====
// ----------------------------------------------------------------------------
// character_cell_grid_engine_top
// Character cell grid of a text display with region scroll and dirty scan.
// ----------------------------------------------------------------------------
// One command at a time through a sequencer over a cell memory with one write
// port and one registered read port. After reset the block sweeps the whole
// store, one cell a cycle, before it takes a command. A write or mark passes
// a read step and then writes the cell; a wide write then writes a tail cell
// as well, and a write or mark outside the grid ends after the read step. A
// read or find result word is registered and then moves to the output
// register; a find reads and checks each cell it scans in turn. The last step
// holds while an earlier word still waits in the output register. Clear writes
// one cell of the store a cycle; mark all and clear dirty read then write each
// cell. A scroll reads then writes each cell of the region.
module character_cell_grid_engine_top import ccg_pkg::*; #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ccg_cmd_if.sink   cmd,
    ccg_res_if.source res,
    ccg_cfg_if.sink   cfg
);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SWEEP = 4'd2;  // clear / mark / unmark whole store
    localparam logic [3:0] S_RD    = 4'd3;  // read issued for single cell
    localparam logic [3:0] S_RDW   = 4'd4;  // data back for single cell
    localparam logic [3:0] S_TAIL  = 4'd5;
    localparam logic [3:0] S_SC_RD = 4'd6;
    localparam logic [3:0] S_SC_WR = 4'd7;
    localparam logic [3:0] S_FD_RD = 4'd8;
    localparam logic [3:0] S_FD_CK = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]  r_state;
    t_cmd        r_cmd;
    logic [7:0]  r_cols_cfg;
    logic [6:0]  r_rows_cfg;
    logic [8:0]  r_cols;        // effective
    logic [7:0]  r_rows;
    logic [AW:0] r_sweep;
    logic [8:0]  r_c;
    logic [7:0]  r_r;
    logic [8:0]  r_left, r_right;
    logic [7:0]  r_top, r_bot, r_n;
    logic        r_up, r_blank_all;
    t_res        r_res;
    t_res        r_out;
    logic        r_res_valid;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_cell         w_wdata, w_rdata;

    ccg_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [8:0] c, input logic [7:0] r);
        addr_of = {r[RW-1:0], c[CW-1:0]};
    endfunction

    // effective size from config
    logic [8:0] w_cols_eff;
    logic [7:0] w_rows_eff;
    always_comb begin
        w_cols_eff = {1'b0, r_cols_cfg};
        if (r_cols_cfg == 8'd0) w_cols_eff = 9'd1;
        else if ({1'b0, r_cols_cfg} > 9'(MAX_COLUMNS)) w_cols_eff = 9'(MAX_COLUMNS);
        w_rows_eff = {1'b0, r_rows_cfg};
        if (r_rows_cfg == 7'd0) w_rows_eff = 8'd1;
        else if ({1'b0, r_rows_cfg} > 8'(MAX_ROWS)) w_rows_eff = 8'(MAX_ROWS);
    end

    // result moves to the output register once that register is free
    logic w_out_load;
    assign w_out_load = (r_state == S_OUT) && (!r_res_valid || res.ready);

    assign cfg.ready = 1'b1;
    assign cmd.ready = (r_state == S_IDLE);
    assign res.valid = r_res_valid;
    assign res.data  = r_out;

    // scroll source row
    logic [7:0] w_src_r;
    logic       w_sc_blank;
    assign w_src_r    = r_up ? r_r + r_n : r_r - r_n;
    assign w_sc_blank = r_blank_all || (r_up ? (w_src_r >= r_bot)
                                             : (r_r < r_top + r_n));

    logic w_inside;
    assign w_inside = ({1'b0, r_cmd.cell_col} < r_cols) && ({1'b0, r_cmd.cell_row} < r_rows);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = addr_of(r_c, r_r);
        w_wdata = BLANK_CELL;
        w_raddr = addr_of(r_c, r_r);
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_sweep[AW-1:0];
            end
            S_SWEEP: begin
                w_waddr = r_sweep[AW-1:0];
                w_raddr = r_sweep[AW-1:0];
            end
            S_SC_RD: w_raddr = addr_of(r_c, w_src_r);
            default: ;
        endcase
        // mark all / clear dirty sweep writes on the write step of each read/write pair; handled in S_SWEEP below
        if (r_state == S_SWEEP && r_cmd.kind == K_CLEAR) begin
            w_we    = 1'b1;
        end
        if (r_state == S_SWEEP && r_cmd.kind != K_CLEAR && r_sweep[AW] == 1'b0 && r_c[0]) begin
            w_we    = 1'b1;
            w_wdata = w_rdata;
            w_wdata.dirty = (r_cmd.kind == K_MARK_ALL);
            w_waddr = r_sweep[AW-1:0];
        end
        if (r_state == S_RDW && r_cmd.kind == K_WRITE) begin
            w_we    = 1'b1;
            w_waddr = addr_of({1'b0, r_cmd.cell_col}, {1'b0, r_cmd.cell_row});
            w_wdata = '{glyph: r_cmd.glyph, attr: r_cmd.attribute, dirty: 1'b1,
                        wide: r_cmd.wide, tail: 1'b0};
        end
        if (r_state == S_RDW && r_cmd.kind == K_MARK) begin
            w_we    = 1'b1;
            w_waddr = addr_of({1'b0, r_cmd.cell_col}, {1'b0, r_cmd.cell_row});
            w_wdata = w_rdata;
            w_wdata.dirty = 1'b1;
        end
        if (r_state == S_TAIL) begin
            w_we    = 1'b1;
            w_waddr = addr_of({1'b0, r_cmd.cell_col} + 9'd1, {1'b0, r_cmd.cell_row});
            w_wdata = '{glyph: BLANK_GLYPH, attr: r_cmd.attribute, dirty: 1'b1,
                        wide: 1'b0, tail: 1'b1};
        end
        if (r_state == S_SC_WR) begin
            w_we    = 1'b1;
            w_waddr = addr_of(r_c, r_r);
            if (!w_sc_blank) begin
                w_wdata = w_rdata;
                w_wdata.dirty = 1'b1;
            end
        end
        if (r_state == S_RD || r_state == S_RDW) begin
            w_raddr = addr_of({1'b0, r_cmd.cell_col}, {1'b0, r_cmd.cell_row});
        end
    end

    // scroll region setup from an accepted command
    logic [8:0] w_right;
    logic [7:0] w_bot, w_mag;
    always_comb begin
        w_right = {1'b0, cmd.data.region_right};
        if (w_right > w_cols_eff) w_right = w_cols_eff;
        w_bot = {1'b0, cmd.data.region_bottom};
        if (w_bot > w_rows_eff) w_bot = w_rows_eff;
        w_mag = cmd.data.scroll_amount[7] ? 8'(-cmd.data.scroll_amount)
                                          : cmd.data.scroll_amount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_cols_cfg  <= 8'd80;
            r_rows_cfg  <= 7'd24;
            r_res_valid <= 1'b0;
        end else begin
            if (cfg.valid) begin
                unique case (cfg.index)
                    CFG_COLS: r_cols_cfg <= cfg.wdata;
                    CFG_ROWS: r_rows_cfg <= cfg.wdata[6:0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_res_valid <= 1'b1;
                r_out       <= r_res;
            end else if (res.ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep[AW-1:0] == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (cmd.valid && cmd.ready) begin
                        r_cmd   <= cmd.data;
                        r_cols  <= w_cols_eff;
                        r_rows  <= w_rows_eff;
                        r_sweep <= '0;
                        r_res   <= '0;
                        unique case (cmd.data.kind) inside
                            K_CLEAR, K_MARK_ALL, K_CLEAR_DIRT: begin
                                r_c     <= '0;
                                r_state <= S_SWEEP;
                            end
                            K_WRITE, K_READ, K_MARK: r_state <= S_RD;
                            K_SCROLL: begin
                                r_top   <= {1'b0, cmd.data.region_top};
                                r_bot   <= w_bot;
                                r_left  <= {1'b0, cmd.data.region_left};
                                r_right <= w_right;
                                r_c     <= {1'b0, cmd.data.region_left};
                                r_n     <= w_mag;
                                r_up    <= !cmd.data.scroll_amount[7];
                                r_blank_all <= w_mag >= (w_bot - {1'b0, cmd.data.region_top});
                                r_r     <= cmd.data.scroll_amount[7] ? w_bot - 8'd1
                                                                     : {1'b0, cmd.data.region_top};
                                if (w_mag == 8'd0 || {1'b0, cmd.data.region_top} >= w_bot
                                    || {1'b0, cmd.data.region_left} >= w_right)
                                    r_state <= S_IDLE;
                                else
                                    r_state <= S_SC_RD;
                            end
                            default: begin
                                // find: normalize start
                                if ({1'b0, cmd.data.cell_col} >= w_cols_eff) begin
                                    r_c <= '0;
                                    r_r <= {1'b0, cmd.data.cell_row} + 8'd1;
                                end else begin
                                    r_c <= {1'b0, cmd.data.cell_col};
                                    r_r <= {1'b0, cmd.data.cell_row};
                                end
                                r_state <= S_FD_RD;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    // clear: one write per cycle; dirty ops: read cycle (r_c[0]=0), write cycle
                    if (r_cmd.kind == K_CLEAR) begin
                        r_sweep <= r_sweep + 1'b1;
                        if (r_sweep[AW-1:0] == AW'(DEPTH - 1)) r_state <= S_IDLE;
                    end else begin
                        r_c[0] <= !r_c[0];
                        if (r_c[0]) begin
                            r_sweep <= r_sweep + 1'b1;
                            if (r_sweep[AW-1:0] == AW'(DEPTH - 1)) r_state <= S_IDLE;
                        end
                    end
                end
                S_RD: begin
                    if (!w_inside) begin
                        if (r_cmd.kind == K_READ) begin
                            r_res.out_glyph <= BLANK_GLYPH;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    if (r_cmd.kind == K_READ) begin
                        r_res.out_glyph     <= w_rdata.glyph;
                        r_res.out_attribute <= w_rdata.attr;
                        r_res.out_dirty     <= w_rdata.dirty;
                        r_res.out_wide      <= w_rdata.wide;
                        r_res.out_wide_tail <= w_rdata.tail;
                        r_res.hit           <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_cmd.kind == K_WRITE && r_cmd.wide
                                 && ({1'b0, r_cmd.cell_col} + 9'd1 < r_cols)) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_TAIL: r_state <= S_IDLE;
                S_SC_RD: r_state <= S_SC_WR;
                S_SC_WR: begin
                    if (r_c + 9'd1 < r_right) begin
                        r_c     <= r_c + 9'd1;
                        r_state <= S_SC_RD;
                    end else begin
                        r_c <= r_left;
                        if (r_up ? (r_r + 8'd1 >= r_bot) : (r_r == r_top)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_r     <= r_up ? r_r + 8'd1 : r_r - 8'd1;
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_FD_RD: begin
                    if (r_r >= r_rows) r_state <= S_OUT;
                    else r_state <= S_FD_CK;
                end
                S_FD_CK: begin
                    if (w_rdata.dirty) begin
                        r_res.hit       <= 1'b1;
                        r_res.found_col <= r_c[6:0];
                        r_res.found_row <= r_r[5:0];
                        r_state <= S_OUT;
                    end else begin
                        if (r_c + 9'd1 < r_cols) begin
                            r_c <= r_c + 9'd1;
                        end else begin
                            r_c <= '0;
                            r_r <= r_r + 8'd1;
                        end
                        r_state <= S_FD_RD;
                    end
                end
                S_OUT: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/ccg_store.sv =====
// ----------------------------------------------------------------------------
// ccg_store
// Cell memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccg_store import ccg_pkg::*; #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);
    t_cell r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character cell grid engine. Commands go in on a
// valid/ready channel, and a local copy of the cell store predicts every read
// and find word. The run covers several grid sizes and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import ccg_pkg::*;

    localparam int NCOL = 128;
    localparam int NROW = 64;

    logic i_clk;
    logic i_rst_n;

    ccg_cmd_if cmd_if ();
    ccg_res_if res_if ();
    ccg_cfg_if cfg_if ();

    character_cell_grid_engine_top #(.MAX_COLUMNS(NCOL), .MAX_ROWS(NROW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cmd     (cmd_if.sink),
        .res     (res_if.source),
        .cfg     (cfg_if.sink)
    );

    // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
    int   idle_mode;
    int   n_err;
    t_cmd cmd_q[$];
    t_res want_q[$];

    // local copy of the store and size registers
    t_cell      grid[NCOL*NROW];
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    function automatic int clamp_dim(int v, int m);
        return (v < 1) ? 1 : ((v > m) ? m : v);
    endfunction

    function automatic t_cell blank_cell();
        t_cell b;
        b = '{glyph: BLANK_GLYPH, attr: 16'd0, dirty: 1'b1, wide: 1'b0, tail: 1'b0};
        return b;
    endfunction

    task automatic send_cmd(t_cmd k);
        cmd_q = {cmd_q, k};
    endtask

    task automatic grid_scroll(int top, int bot, int lft, int rgt, int amt, int nc, int nr);
        int n;
        int h;
        if (amt == 0) return;
        if (rgt > nc) rgt = nc;
        if (bot > nr) bot = nr;
        if (top >= bot || lft >= rgt) return;
        h = bot - top;
        n = (amt > 0) ? amt : -amt;
        if (n >= h) begin
            for (int r = top; r < bot; r++)
                for (int c = lft; c < rgt; c++) grid[r*NCOL+c] = blank_cell();
            return;
        end
        if (amt > 0) begin
            for (int r = top; r < bot - n; r++)
                for (int c = lft; c < rgt; c++) grid[r*NCOL+c] = grid[(r+n)*NCOL+c];
            for (int r = bot - n; r < bot; r++)
                for (int c = lft; c < rgt; c++) grid[r*NCOL+c] = blank_cell();
        end else begin
            for (int r = bot - 1; r >= top + n; r--)
                for (int c = lft; c < rgt; c++) grid[r*NCOL+c] = grid[(r-n)*NCOL+c];
            for (int r = top; r < top + n; r++)
                for (int c = lft; c < rgt; c++) grid[r*NCOL+c] = blank_cell();
        end
        for (int r = top; r < bot; r++)
            for (int c = lft; c < rgt; c++) grid[r*NCOL+c].dirty = 1'b1;
    endtask

    // apply one accepted command to the store copy, queue the word it returns
    task automatic grid_apply(t_cmd k);
        int   nc;
        int   nr;
        int   col;
        int   row;
        bit   in_grid;
        t_res o;
        nc = clamp_dim(cols_reg, NCOL);
        nr = clamp_dim(rows_reg, NROW);
        col = k.cell_col;
        row = k.cell_row;
        in_grid = (col < nc) && (row < nr);
        o = '0;
        case (k.kind)
            K_CLEAR: foreach (grid[i]) grid[i] = blank_cell();
            K_WRITE: if (in_grid) begin
                grid[row*NCOL+col] = '{glyph: k.glyph, attr: k.attribute, dirty: 1'b1,
                                       wide: k.wide, tail: 1'b0};
                if (k.wide && col + 1 < nc)
                    grid[row*NCOL+col+1] = '{glyph: BLANK_GLYPH, attr: k.attribute,
                                             dirty: 1'b1, wide: 1'b0, tail: 1'b1};
            end
            K_READ: begin
                if (in_grid) begin
                    o.out_glyph     = grid[row*NCOL+col].glyph;
                    o.out_attribute = grid[row*NCOL+col].attr;
                    o.out_dirty     = grid[row*NCOL+col].dirty;
                    o.out_wide      = grid[row*NCOL+col].wide;
                    o.out_wide_tail = grid[row*NCOL+col].tail;
                    o.hit           = 1'b1;
                end else begin
                    o.out_glyph = BLANK_GLYPH;
                end
                want_q = {want_q, o};
            end
            K_SCROLL: grid_scroll(k.region_top, k.region_bottom, k.region_left,
                                  k.region_right, $signed(k.scroll_amount), nc, nr);
            K_MARK: if (in_grid) grid[row*NCOL+col].dirty = 1'b1;
            K_MARK_ALL: foreach (grid[i]) grid[i].dirty = 1'b1;
            K_CLEAR_DIRT: foreach (grid[i]) grid[i].dirty = 1'b0;
            default: begin
                if (col >= nc) begin
                    col = 0;
                    row++;
                end
                while (row < nr && !o.hit) begin
                    while (col < nc && !o.hit) begin
                        if (grid[row*NCOL+col].dirty) begin
                            o.hit       = 1'b1;
                            o.found_col = col[6:0];
                            o.found_row = row[5:0];
                        end
                        col++;
                    end
                    row++;
                    col = 0;
                end
                want_q = {want_q, o};
            end
        endcase
    endtask

    function automatic t_cmd cell_cmd(logic [2:0] kd, int col, int row, int g, int a, bit w);
        t_cmd k;
        k               = '0;
        k.region_top    = 7'($urandom);
        k.region_bottom = 7'($urandom);
        k.region_left   = 8'($urandom);
        k.region_right  = 8'($urandom);
        k.scroll_amount = 8'($urandom);
        k.kind          = kd;
        k.cell_col      = col[7:0];
        k.cell_row      = row[6:0];
        k.glyph         = g[20:0];
        k.attribute     = a[15:0];
        k.wide          = w;
        return k;
    endfunction

    function automatic t_cmd scroll_cmd(int top, int bot, int lft, int rgt, int amt);
        t_cmd k;
        k = cell_cmd(K_SCROLL, $urandom_range(255), $urandom_range(127),
                     $urandom_range(1114111), $urandom_range(65535), $urandom_range(1));
        k.region_top    = top[6:0];
        k.region_bottom = bot[6:0];
        k.region_left   = lft[7:0];
        k.region_right  = rgt[7:0];
        k.scroll_amount = amt[7:0];
        return k;
    endfunction

    function automatic t_cmd random_cmd(int nc, int nr);
        int   sel;
        int   col;
        int   row;
        int   amt;
        logic [2:0] kd;
        sel = $urandom_range(999);
        if (sel < 15)       kd = K_CLEAR;
        else if (sel < 30)  kd = K_MARK_ALL;
        else if (sel < 45)  kd = K_CLEAR_DIRT;
        else if (sel < 355) kd = K_WRITE;
        else if (sel < 605) kd = K_READ;
        else if (sel < 725) kd = K_SCROLL;
        else if (sel < 805) kd = K_MARK;
        else                kd = K_FIND;
        if ($urandom_range(99) < 85) begin
            col = $urandom_range(nc - 1);
            row = $urandom_range(nr - 1);
        end else begin
            col = $urandom_range(255);
            row = $urandom_range(127);
        end
        if (kd == K_SCROLL) begin
            amt = ($urandom_range(3) == 0) ? $urandom_range(128) - 64 : $urandom_range(6) - 3;
            if ($urandom_range(4) == 0)
                return scroll_cmd($urandom_range(64), $urandom_range(64), $urandom_range(128),
                                  $urandom_range(128), amt);
            return scroll_cmd($urandom_range(nr - 1), $urandom_range(nr + 1),
                              $urandom_range(nc - 1), $urandom_range(nc + 1), amt);
        end
        return cell_cmd(kd, col, row, $urandom_range(1114111), $urandom_range(65535),
                        $urandom_range(1));
    endfunction

    function automatic bit idle_roll(bit sender);
        case (idle_mode)
            1:       return sender && ($urandom_range(99) < 71);
            2:       return !sender && ($urandom_range(99) < 71);
            3:       return $urandom_range(99) < 6;
            default: return 1'b0;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) grid_apply(cmd_if.data);
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_q.size() > 0 && !idle_roll(1'b1)) begin
                    cmd_if.data  <= cmd_q.pop_front();
                    cmd_if.valid <= 1'b1;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !idle_roll(1'b0);
            if (res_if.valid && res_if.ready) begin
                if (want_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected word %p", res_if.data);
                end else begin
                    want = want_q.pop_front();
                    if (res_if.data.out_glyph !== want.out_glyph ||
                        res_if.data.out_attribute !== want.out_attribute ||
                        res_if.data.out_dirty !== want.out_dirty ||
                        res_if.data.out_wide !== want.out_wide ||
                        res_if.data.out_wide_tail !== want.out_wide_tail ||
                        res_if.data.hit !== want.hit ||
                        res_if.data.found_col !== want.found_col ||
                        res_if.data.found_row !== want.found_row) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch exp %p got %p", want, res_if.data);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (cmd_q.size() > 0 || cmd_if.valid || want_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [7:0] val);
        @(posedge i_clk);
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == CFG_COLS) cols_reg = val;
        else rows_reg = val[6:0];
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int ph_cols[10] = '{8, 0, 16, 255, 5, 128, 12, 1, 128, 9};
        int ph_rows[10] = '{4, 0, 8, 127, 3, 64, 6, 64, 1, 5};
        int ph_num[10]  = '{0, 60, 120, 40, 120, 30, 150, 60, 80, 140};
        int nc;
        int nr;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_COLS;
        cfg_if.wdata = '0;
        idle_mode    = 0;
        n_err        = 0;
        cols_reg     = 8'd80;
        rows_reg     = 7'd24;
        foreach (grid[i]) grid[i] = blank_cell();
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a find right after reset sees the reset-dirty store
        send_cmd(cell_cmd(K_FIND, 0, 0, 0, 0, 0));
        send_cmd(cell_cmd(K_READ, 79, 23, 0, 0, 0));
        for (int p = 0; p < 10; p++) begin
            wait_drained();
            reg_write(CFG_COLS, ph_cols[p][7:0]);
            reg_write(CFG_ROWS, ph_rows[p][7:0]);
            idle_mode = p % 4;
            nc = clamp_dim(ph_cols[p], NCOL);
            nr = clamp_dim(ph_rows[p], NROW);
            if (p == 0) begin
                send_cmd(cell_cmd(K_CLEAR, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_WRITE, 0, 0, 1114111, 65535, 0));
                send_cmd(cell_cmd(K_WRITE, 3, 1, 'h4e2d, 7, 1));
                send_cmd(cell_cmd(K_WRITE, 7, 2, 'h1f600, 9, 1));
                send_cmd(cell_cmd(K_WRITE, 8, 0, 'h41, 1, 0));
                send_cmd(cell_cmd(K_WRITE, 0, 4, 'h42, 1, 0));
                send_cmd(cell_cmd(K_READ, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_READ, 3, 1, 0, 0, 0));
                send_cmd(cell_cmd(K_READ, 4, 1, 0, 0, 0));
                send_cmd(cell_cmd(K_READ, 7, 2, 0, 0, 0));
                send_cmd(cell_cmd(K_READ, 255, 127, 0, 0, 0));
                send_cmd(cell_cmd(K_CLEAR_DIRT, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_FIND, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_MARK, 5, 3, 0, 0, 0));
                send_cmd(cell_cmd(K_MARK, 9, 3, 0, 0, 0));
                send_cmd(cell_cmd(K_FIND, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_FIND, 200, 2, 0, 0, 0));
                send_cmd(cell_cmd(K_FIND, 0, 100, 0, 0, 0));
                send_cmd(scroll_cmd(0, 4, 0, 8, 1));
                send_cmd(scroll_cmd(1, 3, 2, 6, -2));
                send_cmd(scroll_cmd(0, 64, 0, 128, 64));
                send_cmd(scroll_cmd(0, 4, 0, 8, -64));
                send_cmd(scroll_cmd(0, 4, 0, 8, 0));
                send_cmd(scroll_cmd(3, 2, 0, 8, 1));
                send_cmd(cell_cmd(K_MARK_ALL, 0, 0, 0, 0, 0));
                send_cmd(cell_cmd(K_READ, 3, 1, 0, 0, 0));
            end else begin
                // a grid size change without clear now and then
                if (p % 3 != 0) send_cmd(cell_cmd(K_CLEAR, 0, 0, 0, 0, 0));
                for (int i = 0; i < ph_num[p]; i++) send_cmd(random_cmd(nc, nr));
            end
            // trailing read: its word marks the end of all earlier commands
            send_cmd(cell_cmd(K_READ, 0, 0, 0, 0, 0));
        end
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (n_err == 0 && want_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #1000ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule
